[rtl/core/bqp_pkg.sv]
// shared types and constants for the biquadratic bezier patch evaluator
`timescale 1ns / 1ps

package bqp_pkg;

    localparam int GRID       = 3;
    localparam int GRID_LAST  = GRID - 1;
    localparam int GIDX_W     = 2;
    localparam int STORE_DEPTH = GRID * GRID;
    localparam int SIDX_W     = 4;
    localparam int FIELD_W    = 16;
    localparam int NUM_AXES   = 3;

    localparam logic [FIELD_W-1:0] ONE_Q15 = 16'h8000;

    // which bernstein term the weight multiplier forms
    typedef enum logic [1:0] {
        WGT_SS,
        WGT_ST,
        WGT_TT
    } wgt_sel_t;

    // commands from the sequencer to the datapath
    typedef struct packed {
        logic              load_en;
        logic              eval_start;
        logic              wgt_en;
        wgt_sel_t          wgt_sel;
        logic              pw_en;
        logic [GIDX_W-1:0] pt_row;
        logic [GIDX_W-1:0] pt_col;
        logic              acc_en;
        logic              round_en;
    } dp_cmd_t;

endpackage

[rtl/core/bqp_ctrl.sv]
// sequencer: request acceptance, weight and accumulate steps, result strobe
`timescale 1ns / 1ps

module bqp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              action,
    output logic              busy,
    output logic              done,
    output bqp_pkg::dp_cmd_t  cmd
);
    import bqp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WGT,
        S_MAC,
        S_FLUSH,
        S_RND
    } state_t;

    state_t              state_reg;
    logic [GIDX_W-1:0]   cnt_reg;
    logic [GIDX_W-1:0]   row_reg;
    logic [GIDX_W-1:0]   col_reg;
    logic                done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            // strobe follows the rounding step
            done_reg <= (state_reg == S_RND);
            case (state_reg)
                S_IDLE:
                begin
                    if (start && action)
                    begin
                        state_reg <= S_WGT;
                        cnt_reg   <= '0;
                    end
                end
                S_WGT:
                begin
                    if (cnt_reg == GIDX_W'(GRID_LAST))
                    begin
                        state_reg <= S_MAC;
                        row_reg   <= '0;
                        col_reg   <= '0;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_MAC:
                begin
                    if (col_reg == GIDX_W'(GRID_LAST))
                    begin
                        col_reg <= '0;
                        if (row_reg == GIDX_W'(GRID_LAST))
                        begin
                            state_reg <= S_FLUSH;
                        end
                        else
                        begin
                            row_reg <= row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                S_FLUSH:
                begin
                    state_reg <= S_RND;
                end
                S_RND:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.load_en    = (state_reg == S_IDLE) && start && !action;
        cmd.eval_start = (state_reg == S_IDLE) && start && action;
        cmd.wgt_en     = (state_reg == S_WGT);
        cmd.wgt_sel    = wgt_sel_t'(cnt_reg);
        cmd.pw_en      = (state_reg == S_MAC);
        cmd.pt_row     = row_reg;
        cmd.pt_col     = col_reg;
        // first grid point has no product in flight yet
        cmd.acc_en     = ((state_reg == S_MAC) && !(row_reg == '0 && col_reg == '0))
                         || (state_reg == S_FLUSH);
        cmd.round_en   = (state_reg == S_RND);
    end

endmodule

[rtl/core/bqp_datapath.sv]
// control point store, bernstein weights, three accumulate lanes, rounding
`timescale 1ns / 1ps

module bqp_datapath #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  bqp_pkg::dp_cmd_t               cmd,
    input  logic [1:0]                     row,
    input  logic [1:0]                     col,
    input  logic [bqp_pkg::FIELD_W-1:0]    coord_x,
    input  logic [bqp_pkg::FIELD_W-1:0]    coord_y,
    input  logic [bqp_pkg::FIELD_W-1:0]    coord_z,
    input  logic [bqp_pkg::FIELD_W-1:0]    param_u,
    input  logic [bqp_pkg::FIELD_W-1:0]    param_v,
    output logic signed [bqp_pkg::FIELD_W-1:0] point_x,
    output logic signed [bqp_pkg::FIELD_W-1:0] point_y,
    output logic signed [bqp_pkg::FIELD_W-1:0] point_z,
    output logic                           saturated
);
    import bqp_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int IW    = (CW > FIELD_W) ? CW : FIELD_W;
    localparam int PW_W  = 32;
    localparam int ACC_W = CW + PW_W + 1;
    localparam int RES_W = ACC_W - 30;

    localparam logic signed [RES_W-1:0] MAXV = RES_W'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [RES_W-1:0] MINV = -MAXV - RES_W'(1);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< 29);

    // store, cleared at reset
    logic signed [CW-1:0] store_reg [NUM_AXES][STORE_DEPTH];

    logic [FIELD_W-1:0] t_u_reg, t_v_reg;
    logic [FIELD_W-1:0] wu_reg [GRID];
    logic [FIELD_W-1:0] wv_reg [GRID];
    logic [PW_W-1:0]    pw_reg;
    logic signed [CW-1:0]    pc_reg  [NUM_AXES];
    logic signed [ACC_W-1:0] acc_reg [NUM_AXES];
    logic signed [FIELD_W-1:0] point_reg [NUM_AXES];
    logic               sat_reg;

    logic [FIELD_W-1:0] load_raw [NUM_AXES];
    logic [SIDX_W-1:0]  waddr, raddr;
    logic               load_ok;

    assign load_raw[0] = coord_x;
    assign load_raw[1] = coord_y;
    assign load_raw[2] = coord_z;

    assign waddr   = SIDX_W'(row) * SIDX_W'(GRID) + SIDX_W'(col);
    assign raddr   = SIDX_W'(cmd.pt_row) * SIDX_W'(GRID) + SIDX_W'(cmd.pt_col);
    assign load_ok = cmd.load_en && (row <= GIDX_W'(GRID_LAST)) && (col <= GIDX_W'(GRID_LAST));

    function automatic logic [FIELD_W-1:0] clamp_param(input logic [FIELD_W-1:0] p);
        return (p > ONE_Q15) ? ONE_Q15 : p;
    endfunction

    function automatic logic signed [CW-1:0] take_coord(input logic [FIELD_W-1:0] raw);
        logic [IW-1:0] ext;
        ext = IW'(raw);
        return ext[CW-1:0];
    endfunction

    // one bernstein weight, rounded from Q2.30 to Q1.15
    function automatic logic [FIELD_W-1:0] bern(input logic [FIELD_W-1:0] t,
                                                input wgt_sel_t sel);
        logic [FIELD_W-1:0] s, a, b;
        logic [31:0]        prod;
        logic [32:0]        raw;
        s = ONE_Q15 - t;
        case (sel)
            WGT_SS:  begin a = s; b = s; end
            WGT_ST:  begin a = s; b = t; end
            WGT_TT:  begin a = t; b = t; end
            default: begin a = '0; b = '0; end
        endcase
        prod = a * b;
        raw  = (sel == WGT_ST) ? {prod, 1'b0} : {1'b0, prod};
        raw  = raw + 33'd16384;
        return raw[30:15];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                for (int e = 0; e < STORE_DEPTH; e++)
                begin
                    store_reg[k][e] <= '0;
                end
            end
        end
        else if (load_ok)
        begin
            for (int k = 0; k < NUM_AXES; k++)
            begin
                store_reg[k][waddr] <= take_coord(load_raw[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval_start)
        begin
            t_u_reg <= clamp_param(param_u);
            t_v_reg <= clamp_param(param_v);
        end
        if (cmd.wgt_en)
        begin
            wu_reg[cmd.wgt_sel] <= bern(t_u_reg, cmd.wgt_sel);
            wv_reg[cmd.wgt_sel] <= bern(t_v_reg, cmd.wgt_sel);
        end
        if (cmd.pw_en)
        begin
            pw_reg <= wu_reg[cmd.pt_row] * wv_reg[cmd.pt_col];
            for (int k = 0; k < NUM_AXES; k++)
            begin
                pc_reg[k] <= store_reg[k][raddr];
            end
        end
        for (int k = 0; k < NUM_AXES; k++)
        begin
            if (cmd.eval_start)
            begin
                acc_reg[k] <= '0;
            end
            else if (cmd.acc_en)
            begin
                acc_reg[k] <= acc_reg[k] + $signed({1'b0, pw_reg}) * pc_reg[k];
            end
        end
        if (cmd.round_en)
        begin
            logic sat_any;
            sat_any = 1'b0;
            for (int k = 0; k < NUM_AXES; k++)
            begin
                logic signed [ACC_W-1:0] sum;
                logic signed [RES_W-1:0] q;
                logic signed [CW-1:0]    r;
                logic signed [IW-1:0]    wide;
                sum = acc_reg[k] + HALF;
                q   = sum[ACC_W-1:30];
                if (q > MAXV)
                begin
                    r = MAXV[CW-1:0];
                    sat_any = 1'b1;
                end
                else if (q < MINV)
                begin
                    r = MINV[CW-1:0];
                    sat_any = 1'b1;
                end
                else
                begin
                    r = q[CW-1:0];
                end
                wide = IW'(r);
                point_reg[k] <= wide[FIELD_W-1:0];
            end
            sat_reg <= sat_any;
        end
    end

    assign point_x   = point_reg[0];
    assign point_y   = point_reg[1];
    assign point_z   = point_reg[2];
    assign saturated = sat_reg;

endmodule

[rtl/core/biquadratic_bezier_patch_eval_core.sv]
// top level of the biquadratic bezier patch evaluator
`timescale 1ns / 1ps

// usage
//   a request is taken at a rising edge with start high and busy low
//   action 0: load one control point (row, col, coord_x/y/z); row or col
//     above 2 leaves the grid untouched; busy stays low
//   action 1: evaluate at (param_u, param_v), Q1.15, values above 1.0 clamp
//   the result shows on point_x/y/z and saturated for one cycle with done
//   high; busy falls in the same cycle that done rises, and no request
//   is taken while busy, so evaluates do not overlap
//   the sequencer steps an evaluate: 3 weight steps through the u and v
//   weight multipliers, 9 grid points through the per-axis multiply-accumulate
//   lanes, one pipeline flush step and one rounding/saturation step
//   the receiver cannot stall: done is a one-cycle strobe, results stay on
//   the ports until the next result
//   reset clears the whole control grid to zero and returns to idle at once
module biquadratic_bezier_patch_eval_core #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              action,
    input  logic [1:0]                        row,
    input  logic [1:0]                        col,
    input  logic signed [bqp_pkg::FIELD_W-1:0] coord_x,
    input  logic signed [bqp_pkg::FIELD_W-1:0] coord_y,
    input  logic signed [bqp_pkg::FIELD_W-1:0] coord_z,
    input  logic [bqp_pkg::FIELD_W-1:0]       param_u,
    input  logic [bqp_pkg::FIELD_W-1:0]       param_v,
    output logic                              done,
    output logic signed [bqp_pkg::FIELD_W-1:0] point_x,
    output logic signed [bqp_pkg::FIELD_W-1:0] point_y,
    output logic signed [bqp_pkg::FIELD_W-1:0] point_z,
    output logic                              saturated
);
    import bqp_pkg::*;

    dp_cmd_t cmd;

    // sequencer: owns the handshake and steps the datapath
    bqp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .action (action),
        .busy   (busy),
        .done   (done),
        .cmd    (cmd)
    );

    // grid store, weights, accumulate lanes and output registers
    bqp_datapath #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .row       (row),
        .col       (col),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .param_u   (param_u),
        .param_v   (param_v),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .saturated (saturated)
    );

    // an evaluate request keeps the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && action) |=> busy)
        else $error("evaluate request did not raise busy");

    // a load request never occupies the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !action) |=> !busy)
        else $error("load request raised busy");

    // a result strobe lasts one cycle and comes only once the block is free
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe outside end of evaluate");

    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule
